/* hdl/crp_pkg.sv */
// shared types, codes and constants of the capacity range partitioner
`timescale 1ns / 1ps
`default_nettype none
package crp_pkg;

   // default sizing of the bucket table and compared value width
   localparam int MAX_BUCKETS_DEF = 16;
   localparam int VALUE_BITS_DEF  = 32;

   // fixed field widths
   localparam int SLOT_BITS      = 4;
   localparam int WORD_BITS      = 32;
   localparam int FILL_BITS      = 21;
   localparam int COUNT_BITS     = 5;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 21;

   // item kinds
   localparam logic REQ_LOAD     = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT    = 1'd1;

   typedef enum logic [1:0] {
      STATUS_PLACED   = 2'd0,
      STATUS_TRASH    = 2'd1,
      STATUS_NO_MATCH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SKIP
   } state_type;

   typedef struct packed {
      logic                        req_type;
      logic [SLOT_BITS-1:0]        bucket_slot;
      logic signed [WORD_BITS-1:0] range_low;
      logic signed [WORD_BITS-1:0] range_high;
      logic [FILL_BITS-1:0]        start_fill;
      logic signed [WORD_BITS-1:0] row_value;
   } req_payload_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] bucket_index;
      status_type           status;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic       load_we;
      logic       cls_start;
      logic       advance;
      logic       place_we;
      logic       rsp_we;
      status_type rsp_status;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_end;
      logic hit;
      logic full;
   } dp_stat_type;

endpackage
`default_nettype wire

/* hdl/crp_datapath.sv */
// bucket table, walk index, compare logic and result register
`timescale 1ns / 1ps
`default_nettype none
module crp_datapath #(
   parameter int MAX_BUCKETS = crp_pkg::MAX_BUCKETS_DEF,
   parameter int VALUE_BITS  = crp_pkg::VALUE_BITS_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  crp_pkg::req_payload_type               req_payload,
   input  wire                                    csr_we,
   input  wire [crp_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire [crp_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  crp_pkg::dp_cmd_type                    cmd,
   output crp_pkg::dp_stat_type                   stat,
   output logic                                   rsp_valid,
   output crp_pkg::rsp_payload_type               rsp_payload
);
   import crp_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_BUCKETS);
   localparam int CNT_BITS = $clog2(MAX_BUCKETS + 1);
   localparam int CMP_BITS = (VALUE_BITS < WORD_BITS) ? VALUE_BITS : WORD_BITS;
   localparam int NW       = (CNT_BITS > COUNT_BITS) ? CNT_BITS : COUNT_BITS;

   logic [FILL_BITS-1:0]         capacity_ff, capacity_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [CNT_BITS-1:0]          idx_ff, idx_in;
   logic signed [CMP_BITS-1:0]   value_ff, value_in;
   logic [MAX_BUCKETS-1:0]       fill_vld_ff, fill_vld_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_payload_type              rsp_payload_ff, rsp_payload_in;

   logic signed [CMP_BITS-1:0]   low_mem  [MAX_BUCKETS];
   logic signed [CMP_BITS-1:0]   high_mem [MAX_BUCKETS];
   logic [FILL_BITS-1:0]         fill_mem [MAX_BUCKETS];

   logic signed [CMP_BITS-1:0]   low_rd_ff, high_rd_ff;
   logic [FILL_BITS-1:0]         fill_rd_ff;
   logic                         fill_rd_vld_ff;

   logic                         slot_ok, bound_we, fill_we;
   logic [IDX_BITS-1:0]          rd_addr, slot_addr, fill_addr;
   logic [FILL_BITS-1:0]         fill_cur, fill_wr_data;
   logic [CNT_BITS-1:0]          n_eff;

   // buckets in use, clamped to the table size
   always_comb begin
      if (NW'(count_ff) > NW'(MAX_BUCKETS)) begin
         n_eff = CNT_BITS'(MAX_BUCKETS);
      end else begin
         n_eff = CNT_BITS'(count_ff);
      end
   end

   assign slot_ok   = int'(req_payload.bucket_slot) < MAX_BUCKETS;
   assign slot_addr = IDX_BITS'(req_payload.bucket_slot);
   assign bound_we  = cmd.load_we & slot_ok;
   assign fill_we   = cmd.place_we | bound_we;
   assign fill_cur  = fill_rd_vld_ff ? fill_rd_ff : '0;
   assign fill_addr = cmd.place_we ? idx_ff[IDX_BITS-1:0] : slot_addr;
   assign fill_wr_data = cmd.place_we ? fill_cur + FILL_BITS'(1) : req_payload.start_fill;

   always_comb begin
      capacity_in = capacity_ff;
      count_in    = count_ff;
      if (csr_we && csr_index == CSR_CAPACITY) begin
         capacity_in = csr_wdata[FILL_BITS-1:0];
      end
      if (csr_we && csr_index == CSR_COUNT) begin
         count_in = csr_wdata[COUNT_BITS-1:0];
      end

      idx_in = idx_ff;
      if (cmd.cls_start) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + CNT_BITS'(1);
      end

      // read ahead so the data register lines up with idx_ff
      if (idx_in < CNT_BITS'(MAX_BUCKETS)) begin
         rd_addr = idx_in[IDX_BITS-1:0];
      end else begin
         rd_addr = '0;
      end

      value_in = cmd.cls_start ? req_payload.row_value[CMP_BITS-1:0] : value_ff;

      fill_vld_in = fill_vld_ff;
      if (fill_we) begin
         fill_vld_in[fill_addr] = 1'b1;
      end

      rsp_valid_in   = cmd.rsp_we;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.rsp_we) begin
         rsp_payload_in.status = cmd.rsp_status;
         if (cmd.rsp_status == STATUS_PLACED) begin
            rsp_payload_in.bucket_index = SLOT_BITS'(idx_ff[IDX_BITS-1:0]);
         end else begin
            rsp_payload_in.bucket_index = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= FILL_BITS'(65535);
         count_ff     <= COUNT_BITS'(16);
         idx_ff       <= '0;
         fill_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         fill_vld_ff  <= fill_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff       <= value_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // bucket table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (bound_we) begin
         low_mem[slot_addr]  <= req_payload.range_low[CMP_BITS-1:0];
         high_mem[slot_addr] <= req_payload.range_high[CMP_BITS-1:0];
      end
      if (fill_we) begin
         fill_mem[fill_addr] <= fill_wr_data;
      end
      low_rd_ff      <= low_mem[rd_addr];
      high_rd_ff     <= high_mem[rd_addr];
      fill_rd_ff     <= fill_mem[rd_addr];
      fill_rd_vld_ff <= fill_vld_ff[rd_addr];
   end

   assign stat.at_end = idx_ff >= n_eff;
   assign stat.hit    = (low_rd_ff <= value_ff) && (value_ff <= high_rd_ff);
   assign stat.full   = fill_cur >= capacity_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

/* hdl/crp_controller.sv */
// state machine that steers the bucket walk
`timescale 1ns / 1ps
`default_nettype none
module crp_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire                  req_type,
   input  crp_pkg::dp_stat_type stat,
   output crp_pkg::dp_cmd_type  cmd,
   output logic                 busy
);
   import crp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_CLASSIFY) begin
                  cmd.cls_start = 1'b1;
                  state_in      = ST_SEARCH;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         // first bucket whose range holds the value
         ST_SEARCH: begin
            if (stat.at_end) begin
               cmd.rsp_we     = 1'b1;
               cmd.rsp_status = STATUS_NO_MATCH;
               state_in       = ST_IDLE;
            end else if (stat.hit && !stat.full) begin
               cmd.place_we   = 1'b1;
               cmd.rsp_we     = 1'b1;
               cmd.rsp_status = STATUS_PLACED;
               state_in       = ST_IDLE;
            end else begin
               cmd.advance = 1'b1;
               if (stat.hit) begin
                  state_in = ST_SKIP;
               end
            end
         end
         // step past full buckets, then the range must still hold
         ST_SKIP: begin
            if (stat.at_end) begin
               cmd.rsp_we     = 1'b1;
               cmd.rsp_status = STATUS_TRASH;
               state_in       = ST_IDLE;
            end else if (stat.full) begin
               cmd.advance = 1'b1;
            end else if (stat.hit) begin
               cmd.place_we   = 1'b1;
               cmd.rsp_we     = 1'b1;
               cmd.rsp_status = STATUS_PLACED;
               state_in       = ST_IDLE;
            end else begin
               cmd.rsp_we     = 1'b1;
               cmd.rsp_status = STATUS_TRASH;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

endmodule
`default_nettype wire

/* hdl/capacity_range_partitioner_top.sv */
// top level of the capacity range partitioner
`timescale 1ns / 1ps
`default_nettype none
// range partitioner with capacity overflow. a load item (req_type 0) writes one bucket's
// inclusive signed bounds and its starting fill in the cycle it is taken and never raises
// busy. a classify item (req_type 1) walks the bucket table from bucket 0, one bucket a
// cycle through the table's single read port: first to the lowest bucket in use whose
// range holds the value, then onward past buckets whose fill has reached bucket_capacity.
// busy stays high while the walk visits buckets and while it detects the end of the
// buckets in use, that end being bucket_count clamped to the table size, and its
// result strobes on rsp_valid for exactly one cycle right after busy falls; a
// new item may be taken in that same cycle. the receiver cannot hold results off, so
// rsp_payload must be sampled while rsp_valid is high. status 0 means placed (the
// bucket's fill goes up by one), 1 trash (overflow ran off the end or the bucket reached
// no longer holds the value), 2 no range matched; bucket_index reads 0 unless placed.
// a load to a slot beyond the table is dropped. configuration writes on the csr port
// take effect at once and belong only to idle periods. fill counts clear on reset;
// bounds hold nothing until loaded, and classifying against a never loaded bucket
// gives an unspecified answer
module capacity_range_partitioner_top #(
   parameter int MAX_BUCKETS = crp_pkg::MAX_BUCKETS_DEF,
   parameter int VALUE_BITS  = crp_pkg::VALUE_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // item input
   input  wire                                 start,
   output logic                                busy,
   input  crp_pkg::req_payload_type            req_payload,
   // result output
   output logic                                rsp_valid,
   output crp_pkg::rsp_payload_type            rsp_payload,
   // register writes
   input  wire                                 csr_we,
   input  wire [crp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [crp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import crp_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        ctl_busy;

   // sequencing of the walk
   crp_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_payload.req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (ctl_busy)
   );

   // bucket table, comparators and the result register
   crp_datapath #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   assign busy = ctl_busy;

endmodule
`default_nettype wire

/* hdl/crp_checker.sv */
// port level checks of the capacity range partitioner, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module crp_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      start,
   input wire                      busy,
   input crp_pkg::req_payload_type req_payload,
   input wire                      rsp_valid,
   input crp_pkg::rsp_payload_type rsp_payload
);
   import crp_pkg::*;

   // a load finishes in the cycle it is taken
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.req_type == REQ_LOAD |=> !busy)
   else $error("load item raised busy");

   // a classify always occupies the walk
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.req_type == REQ_CLASSIFY |=> busy)
   else $error("classify item did not raise busy");

   // a result only closes a walk
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
   else $error("result without a finished walk");

   // no index unless placed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_PLACED |-> rsp_payload.bucket_index == '0)
   else $error("bucket index set on a row that was not placed");

endmodule

bind capacity_range_partitioner_top crp_checker u_crp_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
